/* sv/eight_bit_harvard_cpu_execute_assert.svh */
// Assertion macros for the 8-bit Harvard core execute block.
// Included by eight_bit_harvard_cpu_execute.sv; no other dependencies.
`ifndef EIGHT_BIT_HARVARD_CPU_EXECUTE_ASSERT_SVH
`define EIGHT_BIT_HARVARD_CPU_EXECUTE_ASSERT_SVH

// same-cycle implication
`define EBHC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EBHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ebhc_pkg.sv */
// Shared types and constants for the 8-bit Harvard core execute block.
// No dependencies; used by the channel interfaces and the top level.
package ebhc_pkg;

   localparam int NUM_REGS_DEF   = 64;
   localparam int DATA_DEPTH_DEF = 2048;
   localparam int WORD_W         = 16;
   localparam int DATA_W         = 8;
   localparam int PC_W           = 16;
   localparam int FLAG_W         = 5;
   localparam int OP_W           = 4;
   localparam int F2_W           = 6;
   localparam int F2_SPAN        = 64;

   localparam int FLAG_C_BIT = 4;
   localparam int FLAG_V_BIT = 3;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_S_BIT = 1;
   localparam int FLAG_Z_BIT = 0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_MOVI = 4'd3,
      OP_BEQZ = 4'd4,
      OP_ANDI = 4'd5,
      OP_EOR  = 4'd6,
      OP_BR   = 4'd7,
      OP_SAL  = 4'd8,
      OP_SAR  = 4'd9,
      OP_LDR  = 4'd10,
      OP_STR  = 4'd11
   } opcode_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic [FLAG_W-1:0] status_flags;
      logic [DATA_W-1:0] written_value;
      logic              branch_taken;
      logic              bad_opcode;
   } rsp_type;

endpackage

/* sv/ebhc_chan_if.sv */
// Valid/ready channel interfaces: instruction in, execute result out.
// Depends on ebhc_pkg for field widths.
interface ebhc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ebhc_pkg::WORD_W-1:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface ebhc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ebhc_pkg::PC_W-1:0]   next_pc;
   logic [ebhc_pkg::FLAG_W-1:0] status_flags;
   logic [ebhc_pkg::DATA_W-1:0] written_value;
   logic                        branch_taken;
   logic                        bad_opcode;

   modport source (output valid, output next_pc, output status_flags,
                   output written_value, output branch_taken, output bad_opcode,
                   input ready);
   modport sink   (input valid, input next_pc, input status_flags,
                   input written_value, input branch_taken, input bad_opcode,
                   output ready);
endinterface

/* sv/eight_bit_harvard_cpu_execute.sv */
// Execute block of an 8-bit Harvard core: register file, data store, PC, flags.
// Depends on ebhc_pkg, ebhc_chan_if.sv and eight_bit_harvard_cpu_execute_assert.svh.
//
//   channel   dir  transfer when       payload
//   req_chan  in   valid && ready      instr_word
//   rsp_chan  out  valid && ready      next_pc, status_flags, written_value,
//                                      branch_taken, bad_opcode
//
// One instruction per cycle sustained while results are taken; the register file and
// data store are read first, then execute writes back into the output register.
// Write back to the next instruction's operands is forwarded at the read.
// Synchronous reset; registers and data entries read as zero until written.
// A held result stalls execute, and execute holds req_chan.ready low.
`include "eight_bit_harvard_cpu_execute_assert.svh"

module eight_bit_harvard_cpu_execute #(
   parameter int NUM_REGS   = ebhc_pkg::NUM_REGS_DEF,
   parameter int DATA_DEPTH = ebhc_pkg::DATA_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ebhc_req_if.sink   req_chan,
   ebhc_rsp_if.source rsp_chan
);
   import ebhc_pkg::*;

   localparam int REG_AW  = $clog2(NUM_REGS);
   localparam int DATA_AW = $clog2(DATA_DEPTH);

   logic [DATA_W-1:0] rf_mem [NUM_REGS];
   logic [DATA_W-1:0] dm_mem [DATA_DEPTH];

   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [F2_SPAN-1:0]  dm_valid_ff;

   logic              accept;
   logic [REG_AW-1:0] in_r1;
   logic [REG_AW-1:0] in_r2;
   logic [F2_W-1:0]   in_f2;

   logic              ex_valid_ff, ex_valid_in;
   logic              ex_advance;
   logic [OP_W-1:0]   ex_op_ff;
   logic [REG_AW-1:0] ex_r1_ff;
   logic [F2_W-1:0]   ex_f2_ff;

   logic [DATA_W-1:0] rf_qa_ff, rf_qb_ff, dm_q_ff;
   logic              a_fwd_ff, b_fwd_ff, m_fwd_ff;
   logic              a_vld_ff, b_vld_ff, m_vld_ff;
   logic [DATA_W-1:0] a_fwd_val_ff, b_fwd_val_ff, m_fwd_val_ff;

   logic [DATA_W-1:0] op_a, op_b, op_m;

   logic              wb_reg_en, wb_mem_en;
   logic [DATA_W-1:0] wb_val;

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [FLAG_W-1:0] status_ff, status_in;
   logic              ex_sets_flags;
   logic              ex_taken, ex_bad;

   logic [DATA_W:0]     sum9, diff9;
   logic [2*DATA_W-1:0] prod;
   logic [PC_W-1:0]     pc_inc;
   logic                flag_c, flag_v;
   logic                reg_wr;

   rsp_type out_ff;
   logic    out_valid_ff, out_valid_in;

   // input decode
   assign in_f2  = req_chan.instr_word[F2_W-1:0];
   assign in_r1  = req_chan.instr_word[F2_W +: REG_AW];
   assign in_r2  = in_f2[REG_AW-1:0];

   assign ex_advance     = ex_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !ex_valid_ff || ex_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ex_valid_in  = accept ? 1'b1 : (ex_advance ? 1'b0 : ex_valid_ff);
   assign out_valid_in = ex_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   assign wb_reg_en = ex_advance && reg_wr;
   assign wb_mem_en = ex_advance && (ex_op_ff == OP_STR);

   // register file: two read ports, one write port
   always_ff @(posedge clock) begin
      if (accept) begin
         rf_qa_ff <= rf_mem[in_r1];
         rf_qb_ff <= rf_mem[in_r2];
      end
      if (wb_reg_en) begin
         rf_mem[ex_r1_ff] <= wb_val;
      end
   end

   // data store
   always_ff @(posedge clock) begin
      if (accept) begin
         dm_q_ff <= dm_mem[DATA_AW'(in_f2)];
      end
      if (wb_mem_en) begin
         dm_mem[DATA_AW'(ex_f2_ff)] <= op_a;
      end
   end

   // operand source capture with forwarding from the write at the same edge
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_op_ff     <= req_chan.instr_word[WORD_W-1 -: OP_W];
         ex_r1_ff     <= in_r1;
         ex_f2_ff     <= in_f2;
         a_fwd_ff     <= wb_reg_en && (ex_r1_ff == in_r1);
         b_fwd_ff     <= wb_reg_en && (ex_r1_ff == in_r2);
         m_fwd_ff     <= wb_mem_en && (ex_f2_ff == in_f2);
         a_vld_ff     <= rf_valid_ff[in_r1];
         b_vld_ff     <= rf_valid_ff[in_r2];
         m_vld_ff     <= dm_valid_ff[in_f2];
         a_fwd_val_ff <= wb_val;
         b_fwd_val_ff <= wb_val;
         m_fwd_val_ff <= op_a;
      end
   end

   assign op_a = a_fwd_ff ? a_fwd_val_ff : (a_vld_ff ? rf_qa_ff : '0);
   assign op_b = b_fwd_ff ? b_fwd_val_ff : (b_vld_ff ? rf_qb_ff : '0);
   assign op_m = m_fwd_ff ? m_fwd_val_ff : (m_vld_ff ? dm_q_ff : '0);

   // execute
   assign sum9   = {1'b0, op_a} + {1'b0, op_b};
   assign diff9  = {1'b0, op_a} - {1'b0, op_b};
   assign prod   = (2*DATA_W)'(op_a) * (2*DATA_W)'(op_b);
   assign pc_inc = pc_ff + PC_W'(1);

   always_comb begin
      wb_val        = '0;
      reg_wr        = 1'b0;
      ex_sets_flags = 1'b0;
      ex_taken      = 1'b0;
      ex_bad        = 1'b0;
      flag_c        = 1'b0;
      flag_v        = 1'b0;
      pc_in         = pc_inc;
      unique case (opcode_type'(ex_op_ff))
         OP_ADD: begin
            wb_val        = sum9[DATA_W-1:0];
            flag_c        = sum9[DATA_W];
            flag_v        = ~(op_a[DATA_W-1] ^ op_b[DATA_W-1])
                            & (op_a[DATA_W-1] ^ sum9[DATA_W-1]);
            reg_wr        = 1'b1;
            ex_sets_flags = 1'b1;
         end
         OP_SUB: begin
            wb_val        = diff9[DATA_W-1:0];
            flag_c        = diff9[DATA_W];
            flag_v        = (op_a[DATA_W-1] ^ op_b[DATA_W-1])
                            & (op_a[DATA_W-1] ^ diff9[DATA_W-1]);
            reg_wr        = 1'b1;
            ex_sets_flags = 1'b1;
         end
         OP_MUL: begin
            wb_val        = prod[DATA_W-1:0];
            flag_c        = |prod[2*DATA_W-1:DATA_W];
            reg_wr        = 1'b1;
            ex_sets_flags = 1'b1;
         end
         OP_MOVI: begin
            wb_val = DATA_W'(ex_f2_ff);
            reg_wr = 1'b1;
         end
         OP_BEQZ: begin
            if (op_a == '0) begin
               pc_in    = pc_inc + PC_W'(ex_f2_ff);
               ex_taken = 1'b1;
            end
         end
         OP_ANDI: begin
            wb_val        = op_a & DATA_W'(ex_f2_ff);
            reg_wr        = 1'b1;
            ex_sets_flags = 1'b1;
         end
         OP_EOR: begin
            wb_val        = op_a ^ op_b;
            reg_wr        = 1'b1;
            ex_sets_flags = 1'b1;
         end
         OP_BR: begin
            pc_in    = {op_a, op_b};
            ex_taken = 1'b1;
         end
         OP_SAL: begin
            wb_val = op_a << ex_f2_ff;
            reg_wr = 1'b1;
         end
         OP_SAR: begin
            wb_val = DATA_W'($signed(op_a) >>> ex_f2_ff);
            reg_wr = 1'b1;
         end
         OP_LDR: begin
            wb_val = op_m;
            reg_wr = 1'b1;
         end
         OP_STR: begin
            wb_val = op_a;
         end
         default: begin
            ex_bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      status_in = status_ff;
      if (ex_sets_flags) begin
         status_in[FLAG_C_BIT] = flag_c;
         status_in[FLAG_V_BIT] = flag_v;
         status_in[FLAG_N_BIT] = wb_val[DATA_W-1];
         status_in[FLAG_S_BIT] = wb_val[DATA_W-1] ^ flag_v;
         status_in[FLAG_Z_BIT] = (wb_val == '0);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         status_ff    <= '0;
         rf_valid_ff  <= '0;
         dm_valid_ff  <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
         if (ex_advance) begin
            pc_ff     <= pc_in;
            status_ff <= status_in;
         end
         if (wb_reg_en) begin
            rf_valid_ff[ex_r1_ff] <= 1'b1;
         end
         if (wb_mem_en) begin
            dm_valid_ff[ex_f2_ff] <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (ex_advance) begin
         out_ff.next_pc       <= pc_in;
         out_ff.status_flags  <= status_in;
         out_ff.written_value <= wb_val;
         out_ff.branch_taken  <= ex_taken;
         out_ff.bad_opcode    <= ex_bad;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.next_pc       = out_ff.next_pc;
   assign rsp_chan.status_flags  = out_ff.status_flags;
   assign rsp_chan.written_value = out_ff.written_value;
   assign rsp_chan.branch_taken  = out_ff.branch_taken;
   assign rsp_chan.bad_opcode    = out_ff.bad_opcode;

   `EBHC_ASSERT_SAME(a_bad_quiet, clock, reset, out_valid_ff && out_ff.bad_opcode,
      (out_ff.written_value == '0) && !out_ff.branch_taken,
      "bad opcode result wrote or branched")
   `EBHC_ASSERT_NEXT(a_adv_out, clock, reset, ex_advance, out_valid_ff,
      "executed instruction left no result")
   `EBHC_ASSERT_NEXT(a_flags_hold, clock, reset, ex_advance && !ex_sets_flags,
      $stable(status_ff), "flags changed on a non-ALU instruction")
   `EBHC_ASSERT_NEXT(a_acc_ex, clock, reset, accept, ex_valid_ff,
      "transfer did not reach execute")

endmodule

/* verif/eight_bit_harvard_cpu_execute_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the 8-bit Harvard core execute block: directed and random
// instructions against an in-bench execute model, with random stalls on both channels.
// Depends on ebhc_pkg, ebhc_chan_if.sv and the eight_bit_harvard_cpu_execute RTL.
module eight_bit_harvard_cpu_execute_tb;
   import ebhc_pkg::*;

   localparam int DM_AW = $clog2(DATA_DEPTH_DEF);

   logic clock;
   logic reset;

   ebhc_req_if req_if ();
   ebhc_rsp_if rsp_if ();

   eight_bit_harvard_cpu_execute u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // execute model state
   logic [DATA_W-1:0] model_regs [NUM_REGS_DEF];
   logic [DATA_W-1:0] model_mem  [DATA_DEPTH_DEF];
   logic [PC_W-1:0]   model_pc;
   logic [FLAG_W-1:0] model_flags;

   rsp_type pending_results [$];

   int src_idle_pct;
   int snk_idle_pct;
   logic long_hold;
   int err_count;
   int checked_count;
   int taken_count;
   int bad_count;
   int sent_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [WORD_W-1:0] enc(opcode_type op, int unsigned r1,
                                             int unsigned f2);
      logic [5:0] r1_bits;
      logic [5:0] f2_bits;
      r1_bits = r1[5:0];
      f2_bits = f2[5:0];
      return {op, r1_bits, f2_bits};
   endfunction

   function automatic logic [FLAG_W-1:0] alu_flags(logic [DATA_W-1:0] res, logic c,
                                                  logic v);
      logic [FLAG_W-1:0] f;
      f = '0;
      f[FLAG_C_BIT] = c;
      f[FLAG_V_BIT] = v;
      f[FLAG_N_BIT] = res[7];
      f[FLAG_S_BIT] = res[7] ^ v;
      f[FLAG_Z_BIT] = (res == '0);
      return f;
   endfunction

   function automatic rsp_type predict_exec(logic [WORD_W-1:0] word);
      rsp_type r;
      logic [5:0] r1;
      logic [5:0] f2;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W:0] sum;
      logic [15:0] prod;
      logic [DATA_W-1:0] res;
      logic signed [DATA_W-1:0] sa;
      logic [DM_AW-1:0] addr;
      r1 = word[11:6];
      f2 = word[5:0];
      a = model_regs[r1];
      b = model_regs[f2];
      addr = DM_AW'(f2);
      r = '0;
      model_pc = model_pc + 16'd1;
      case (word[15:12])
         OP_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            res = sum[7:0];
            model_flags = alu_flags(res, sum[8], ~(a[7] ^ b[7]) & (a[7] ^ res[7]));
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_SUB: begin
            res = a - b;
            model_flags = alu_flags(res, a < b, (a[7] ^ b[7]) & (a[7] ^ res[7]));
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_MUL: begin
            prod = {8'd0, a} * {8'd0, b};
            res = prod[7:0];
            model_flags = alu_flags(res, prod > 16'hFF, 1'b0);
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_MOVI: begin
            model_regs[r1] = {2'b00, f2};
            r.written_value = {2'b00, f2};
         end
         OP_BEQZ: begin
            if (a == '0) begin
               model_pc = model_pc + {10'd0, f2};
               r.branch_taken = 1'b1;
            end
         end
         OP_ANDI: begin
            res = a & {2'b00, f2};
            model_flags = alu_flags(res, 1'b0, 1'b0);
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_EOR: begin
            res = a ^ b;
            model_flags = alu_flags(res, 1'b0, 1'b0);
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_BR: begin
            model_pc = {a, b};
            r.branch_taken = 1'b1;
         end
         OP_SAL: begin
            res = (f2 >= 6'd8) ? 8'd0 : (a << f2);
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_SAR: begin
            sa = a;
            res = (f2 >= 6'd8) ? (sa >>> 8) : (sa >>> f2);
            model_regs[r1] = res;
            r.written_value = res;
         end
         OP_LDR: begin
            model_regs[r1] = model_mem[addr];
            r.written_value = model_mem[addr];
         end
         OP_STR: begin
            model_mem[addr] = a;
            r.written_value = a;
         end
         default: r.bad_opcode = 1'b1;
      endcase
      r.next_pc = model_pc;
      r.status_flags = model_flags;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rand_instr();
      int unsigned pick;
      int unsigned op;
      int unsigned f2;
      pick = $urandom_range(99);
      if (pick < 5)
         return {4'($urandom_range(15, 12)), 12'($urandom)};
      op = $urandom_range(OP_STR);
      f2 = $urandom_range(63);
      if ((op == OP_SAL || op == OP_SAR) && $urandom_range(1))
         f2 = $urandom_range(8);
      return enc(opcode_type'(op), $urandom_range(63), f2);
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      if (err_count < 40)
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
      err_count++;
   endtask

   task automatic check_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected transfer, next_pc", rsp_if.next_pc, 16'h0);
         return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (want.branch_taken) taken_count++;
      if (want.bad_opcode) bad_count++;
      if (rsp_if.next_pc !== want.next_pc)
         report_mismatch("next_pc", rsp_if.next_pc, want.next_pc);
      if (rsp_if.status_flags !== want.status_flags)
         report_mismatch("status_flags", 16'(rsp_if.status_flags),
                         16'(want.status_flags));
      if (rsp_if.written_value !== want.written_value)
         report_mismatch("written_value", 16'(rsp_if.written_value),
                         16'(want.written_value));
      if (rsp_if.branch_taken !== want.branch_taken)
         report_mismatch("branch_taken", 16'(rsp_if.branch_taken),
                         16'(want.branch_taken));
      if (rsp_if.bad_opcode !== want.bad_opcode)
         report_mismatch("bad_opcode", 16'(rsp_if.bad_opcode), 16'(want.bad_opcode));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !long_hold && ($urandom_range(99) >= snk_idle_pct);
         if (rsp_if.valid && rsp_if.ready)
            check_result();
      end
   end

   task automatic send_instr(input logic [WORD_W-1:0] word);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < src_idle_pct)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.instr_word <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_results.push_back(predict_exec(word));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_directed_ops();
      logic [WORD_W-1:0] words [$];
      words = '{
         enc(OP_MOVI, 1, 63), enc(OP_MOVI, 2, 1), enc(OP_ADD, 1, 2),
         enc(OP_ADD, 1, 1), enc(OP_ADD, 1, 1), enc(OP_SUB, 3, 2),
         enc(OP_MUL, 3, 3), enc(OP_SUB, 4, 2), enc(OP_SAR, 4, 3),
         enc(OP_MOVI, 5, 63), enc(OP_SAL, 5, 2), enc(OP_SAR, 5, 63),
         enc(OP_SAL, 5, 8), enc(OP_ANDI, 4, 63), enc(OP_EOR, 4, 4),
         enc(OP_STR, 2, 63), enc(OP_LDR, 63, 63), enc(OP_LDR, 62, 0),
         enc(OP_BEQZ, 0, 63), enc(OP_BEQZ, 2, 5), enc(OP_SUB, 10, 2),
         enc(OP_BR, 10, 10), enc(OP_BEQZ, 0, 63), 16'hC000, 16'hFFFF, 16'h0000
      };
      foreach (words[i]) send_instr(words[i]);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                      input int count);
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      repeat (count) send_instr(rand_instr());
      wait_drained();
   endtask

   // long receiver hold while the sender keeps offering, so the block fills and stalls
   task automatic test_backpressure();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      fork
         begin
            long_hold <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold <= 1'b0;
         end
         repeat (60) send_instr(rand_instr());
      join
      wait_drained();
   endtask

   initial begin
      foreach (model_regs[i]) model_regs[i] = '0;
      foreach (model_mem[i]) model_mem[i] = '0;
      model_pc = '0;
      model_flags = '0;
      err_count = 0;
      checked_count = 0;
      taken_count = 0;
      bad_count = 0;
      sent_count = 0;
      src_idle_pct = 0;
      snk_idle_pct = 0;
      long_hold <= 1'b0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.instr_word <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_directed_ops();
      test_random_traffic(26, 55, 650);
      test_random_traffic(55, 26, 650);
      test_random_traffic(0, 0, 650);
      test_backpressure();

      $display("covered %0d instructions sent, %0d results checked", sent_count,
               checked_count);
      $display("  %0d branches taken, %0d bad opcodes, %0d mismatches", taken_count,
               bad_count, err_count);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
